// ----- design/ace_pkg.sv -----
// Shared types and constants for the ARP responder with a one-entry cache.
// No dependencies; used by every module of the block.
package ace_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_TIMEOUT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PENDING_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES     = 3'd4;

    // command codes
    localparam logic CMD_PAYLOAD = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // ARP field values
    localparam logic [10:0] MIN_ARP_LEN   = 11'd28;
    localparam logic [15:0] HW_TYPE_ETH   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IP4 = 8'd4;
    localparam logic [15:0] OP_REQUEST    = 16'd1;
    localparam logic [15:0] OP_REPLY      = 16'd2;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // entry state codes as seen on entry_state
    localparam logic [1:0] CODE_FREE    = 2'd0;
    localparam logic [1:0] CODE_OK      = 2'd1;
    localparam logic [1:0] CODE_PENDING = 2'd2;

    // reset values of the timing registers
    localparam logic [7:0] RST_OK_TIMEOUT      = 8'd5;
    localparam logic [7:0] RST_PENDING_TIMEOUT = 8'd1;
    localparam logic [7:0] RST_MAX_RETRIES     = 8'd5;

    typedef enum logic [2:0] {
        ENT_FREE    = 3'b001,
        ENT_OK      = 3'b010,
        ENT_PENDING = 3'b100
    } ent_state_t;

    typedef struct packed {
        logic        cmd;
        logic [10:0] arp_length;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic        send_is_reply;
        logic [47:0] send_dest_mac;
        logic [47:0] send_target_mac;
        logic [31:0] send_target_ip;
        logic [1:0]  entry_state;
        logic [31:0] entry_ip;
        logic [47:0] entry_mac;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- design/ace_in_stage.sv -----
// Input register of the ARP cache engine: holds one accepted beat.
// Depends on ace_pkg for the item type.
module ace_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ace_pkg::item_t item_in,
    input  logic           can_load,
    output logic           step,
    output ace_pkg::item_t item_out
);

    logic           valid_reg;
    logic           valid_next;
    ace_pkg::item_t item_reg;

    // the held beat moves on whenever the result register can take it
    assign step     = valid_reg && can_load;
    assign in_ready = !valid_reg || can_load;
    assign item_out = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// ----- design/ace_core.sv -----
// Packet checks, cache entry state and configuration registers.
// Depends on ace_pkg for item, result and state types.
module ace_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  ace_pkg::cfg_wr_t cfg,
    input  logic             step,
    input  ace_pkg::item_t   item,
    output ace_pkg::result_t result
);

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic [7:0]  ok_timeout_reg;
    logic [7:0]  pending_timeout_reg;
    logic [7:0]  max_retries_reg;

    ace_pkg::ent_state_t state_reg, state_next;
    logic [31:0] ip_reg, ip_next;
    logic [47:0] mac_reg, mac_next;
    logic [7:0]  ticks_reg, ticks_next;
    logic [7:0]  retries_reg, retries_next;

    logic pkt_ok;
    logic expire;
    logic send_req;

    // own_mac is the sender of our packets; it is kept for the framer side
    logic unused_own_mac;
    assign unused_own_mac = ^own_mac_reg;

    assign pkt_ok = (item.arp_length >= ace_pkg::MIN_ARP_LEN)
                 && (item.hw_type == ace_pkg::HW_TYPE_ETH)
                 && (item.proto_type == ace_pkg::PROTO_IPV4)
                 && (item.hw_len == ace_pkg::HW_LEN_ETH)
                 && (item.proto_len == ace_pkg::PROTO_LEN_IP4)
                 && ((item.opcode == ace_pkg::OP_REQUEST)
                     || (item.opcode == ace_pkg::OP_REPLY))
                 && (item.dst_ip == own_ip_reg);

    // zero or one left: expires now, no wrap
    assign expire = (ticks_reg <= 8'd1);

    always_comb
    begin
        state_next   = state_reg;
        ip_next      = ip_reg;
        mac_next     = mac_reg;
        ticks_next   = ticks_reg;
        retries_next = retries_reg;
        send_req     = 1'b0;

        result.send_valid      = 1'b0;
        result.send_is_reply   = 1'b0;
        result.send_dest_mac   = '0;
        result.send_target_mac = '0;
        result.send_target_ip  = '0;

        if (item.cmd == ace_pkg::CMD_PAYLOAD)
        begin
            if (pkt_ok)
            begin
                if (item.opcode == ace_pkg::OP_REQUEST)
                begin
                    result.send_valid      = 1'b1;
                    result.send_is_reply   = 1'b1;
                    result.send_dest_mac   = item.src_mac;
                    result.send_target_mac = item.src_mac;
                    result.send_target_ip  = item.src_ip;
                end
                ip_next      = item.src_ip;
                mac_next     = item.src_mac;
                state_next   = ace_pkg::ENT_OK;
                ticks_next   = ok_timeout_reg;
                retries_next = max_retries_reg;
            end
        end
        else
        begin
            unique case (state_reg)
                ace_pkg::ENT_OK:
                begin
                    if (expire)
                    begin
                        send_req   = 1'b1;
                        state_next = ace_pkg::ENT_PENDING;
                        ticks_next = pending_timeout_reg;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                end
                ace_pkg::ENT_PENDING:
                begin
                    if (expire)
                    begin
                        if (retries_reg == 8'd0)
                        begin
                            state_next = ace_pkg::ENT_FREE;
                            ticks_next = 8'd0;
                        end
                        else
                        begin
                            send_req     = 1'b1;
                            retries_next = retries_reg - 8'd1;
                            ticks_next   = pending_timeout_reg;
                        end
                    end
                    else
                    begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        if (send_req)
        begin
            result.send_valid      = 1'b1;
            result.send_is_reply   = 1'b0;
            result.send_dest_mac   = ace_pkg::BCAST_MAC;
            result.send_target_mac = '0;
            result.send_target_ip  = ip_reg;
        end

        unique case (state_next)
            ace_pkg::ENT_OK:      result.entry_state = ace_pkg::CODE_OK;
            ace_pkg::ENT_PENDING: result.entry_state = ace_pkg::CODE_PENDING;
            default:              result.entry_state = ace_pkg::CODE_FREE;
        endcase
        result.entry_ip  = ip_next;
        result.entry_mac = mac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg          <= '0;
            own_mac_reg         <= '0;
            ok_timeout_reg      <= ace_pkg::RST_OK_TIMEOUT;
            pending_timeout_reg <= ace_pkg::RST_PENDING_TIMEOUT;
            max_retries_reg     <= ace_pkg::RST_MAX_RETRIES;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                ace_pkg::CFG_OWN_IP:          own_ip_reg <= cfg.data[31:0];
                ace_pkg::CFG_OWN_MAC:         own_mac_reg <= cfg.data[47:0];
                ace_pkg::CFG_OK_TIMEOUT:      ok_timeout_reg <= cfg.data[7:0];
                ace_pkg::CFG_PENDING_TIMEOUT: pending_timeout_reg <= cfg.data[7:0];
                ace_pkg::CFG_MAX_RETRIES:     max_retries_reg <= cfg.data[7:0];
                default:                      own_ip_reg <= own_ip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ace_pkg::ENT_FREE;
            ip_reg      <= '0;
            mac_reg     <= '0;
            ticks_reg   <= '0;
            retries_reg <= '0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            ip_reg      <= ip_next;
            mac_reg     <= mac_next;
            ticks_reg   <= ticks_next;
            retries_reg <= retries_next;
        end
    end

endmodule

// ----- design/ace_out_stage.sv -----
// Result register of the ARP cache engine with its valid/ready control.
// Depends on ace_pkg for the result type.
module ace_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ace_pkg::result_t result_in,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output ace_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    ace_pkg::result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// ----- design/arp_cache_entry_engine.sv -----
// ARP responder with a one-entry address cache: top level.
// Depends on ace_pkg, ace_in_stage, ace_core and ace_out_stage.
//
// Input channel (in_valid/in_ready): one beat is a parsed ARP payload
// (cmd = 0) or a timer tick (cmd = 1). Output channel (out_valid/out_ready):
// exactly one result beat per input beat, in order, carrying the packet to
// send (if any) and the cache entry after the step.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 own_ip,
// 1 own_mac, 2 ok_timeout, 3 pending_timeout, 4 max_retries); other
// indexes are ignored. Write only while no beat is in flight.
// Pipeline: a beat accepted into the input register passes through the core
// logic into the result register (two register stages).
// Throughput: one beat per cycle while out_ready is high; the entry update is
// combinational compares and an 8-bit decrement, so the state feeds straight back.
// Stall: while out_ready is low the result holds and one more beat can sit
// in the input register; in_ready drops only when both are full.
// Reset: entry free, address and counters zero, timeouts 5/1, retries 5.
module arp_cache_entry_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [10:0] arp_length,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [7:0]  hw_len,
    input  logic [7:0]  proto_len,
    input  logic [15:0] opcode,
    input  logic [47:0] src_mac,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_valid,
    output logic        send_is_reply,
    output logic [47:0] send_dest_mac,
    output logic [47:0] send_target_mac,
    output logic [31:0] send_target_ip,
    output logic [1:0]  entry_state,
    output logic [31:0] entry_ip,
    output logic [47:0] entry_mac
);

    ace_pkg::item_t   item_in;
    ace_pkg::item_t   item_held;
    ace_pkg::result_t result_comb;
    ace_pkg::result_t result_out;
    ace_pkg::cfg_wr_t cfg;
    logic             step;
    logic             can_load;

    assign item_in.cmd        = cmd;
    assign item_in.arp_length = arp_length;
    assign item_in.hw_type    = hw_type;
    assign item_in.proto_type = proto_type;
    assign item_in.hw_len     = hw_len;
    assign item_in.proto_len  = proto_len;
    assign item_in.opcode     = opcode;
    assign item_in.src_mac    = src_mac;
    assign item_in.src_ip     = src_ip;
    assign item_in.dst_ip     = dst_ip;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ace_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item_in  (item_in),
        .can_load (can_load),
        .step     (step),
        .item_out (item_held)
    );

    ace_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (item_held),
        .result (result_comb)
    );

    ace_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .result_in  (result_comb),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign send_valid      = result_out.send_valid;
    assign send_is_reply   = result_out.send_is_reply;
    assign send_dest_mac   = result_out.send_dest_mac;
    assign send_target_mac = result_out.send_target_mac;
    assign send_target_ip  = result_out.send_target_ip;
    assign entry_state     = result_out.entry_state;
    assign entry_ip        = result_out.entry_ip;
    assign entry_mac       = result_out.entry_mac;

endmodule
